/* design/b2da_pkg.sv */
// ----------------------------------------------------------------------------
// b2da_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package b2da_pkg;

   localparam int unsigned NUM_DIGITS = 10;
   localparam int unsigned VALUE_W    = 32;
   localparam int unsigned DIGIT_W    = 4;
   localparam int unsigned POS_W      = 4;
   localparam int unsigned CHAR_W     = 8;
   localparam int unsigned WIDE_W     = 36;   // holds 9 x 10^9

   localparam logic [CHAR_W-1:0]  ASCII_ZERO = 8'd48;
   localparam logic [CHAR_W-1:0]  BLANK_RST  = 8'd32;
   localparam logic [POS_W-1:0]   LAST_POS   = 4'd9;
   localparam logic [DIGIT_W-1:0] MAX_DIGIT  = 4'd9;

   // Place weights, most significant digit first.
   localparam logic [NUM_DIGITS-1:0][WIDE_W-1:0] PLACE_WEIGHT = '{
      36'd1000000000, 36'd100000000, 36'd10000000, 36'd1000000, 36'd100000,
      36'd10000, 36'd1000, 36'd100, 36'd10, 36'd1
   };

   // One item in flight through the digit pipeline.
   typedef struct packed {
      logic [VALUE_W-1:0]                  rest;
      logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits;
      logic [NUM_DIGITS-1:0]               blank;
      logic                                seen;
   } pipe_type;

endpackage

/* design/b2da_stage.sv */
// ----------------------------------------------------------------------------
// b2da_stage
// One pipeline stage: extracts one decimal digit by comparing the remainder
// against the nine constant multiples of its place weight.
// ----------------------------------------------------------------------------
module b2da_stage
   import b2da_pkg::*;
#(
   parameter int unsigned IDX = 0
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  pipe_type in_data,
   output logic     in_take,
   output logic     out_valid,
   output pipe_type out_data,
   input  logic     out_take
);

   localparam logic [WIDE_W-1:0] W = PLACE_WEIGHT[NUM_DIGITS-1-IDX];

   logic              valid_ff;
   pipe_type          data_ff;
   pipe_type          data_in;
   logic [DIGIT_W-1:0] digit;
   logic [WIDE_W-1:0] sub;
   logic [WIDE_W-1:0] rest_wide;

   // PLACE_WEIGHT is declared as a packed array, index 0 is the last entry
   always_comb begin
      rest_wide = {{(WIDE_W-VALUE_W){1'b0}}, in_data.rest};
      digit     = '0;
      sub       = '0;
      for (int j = 1; j <= int'(MAX_DIGIT); j++) begin
         if (rest_wide >= W * WIDE_W'(j)) begin
            digit = DIGIT_W'(j);
            sub   = W * WIDE_W'(j);
         end
      end
      data_in             = in_data;
      data_in.rest        = VALUE_W'(rest_wide - sub);
      data_in.digits[IDX] = digit;
      data_in.seen        = in_data.seen | (digit != '0);
      data_in.blank[IDX]  = !(in_data.seen | (digit != '0));
   end

   assign in_take   = !valid_ff || out_take;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_take) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

/* design/b2da_ser.sv */
// ----------------------------------------------------------------------------
// b2da_ser
// Output serializer: sends the ten characters of one converted value as ten
// beats, substituting the blank character for leading zeros.
// ----------------------------------------------------------------------------
module b2da_ser
   import b2da_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic [CHAR_W-1:0] blank_char,
   input  logic              in_valid,
   input  pipe_type          in_data,
   output logic              in_take,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CHAR_W-1:0] rsp_char_out,
   output logic [POS_W-1:0]  rsp_digit_pos,
   output logic              rsp_last
);

   logic                                busy_ff;
   logic [POS_W-1:0]                    cnt_ff;
   logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_ff;
   logic [NUM_DIGITS-1:0]               blank_ff;
   logic                                beat;
   logic                                last_beat;

   assign beat      = busy_ff && !rsp_stall;
   assign last_beat = beat && (cnt_ff == LAST_POS);
   assign in_take   = !busy_ff || last_beat;

   assign rsp_valid     = busy_ff;
   assign rsp_digit_pos = cnt_ff;
   assign rsp_last      = (cnt_ff == LAST_POS);
   assign rsp_char_out  = blank_ff[cnt_ff] ? blank_char
                        : ASCII_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digits_ff[cnt_ff]};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (in_take) begin
         busy_ff <= in_valid;
         cnt_ff  <= '0;
      end else if (beat) begin
         cnt_ff <= cnt_ff + POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (in_take && in_valid) begin
         digits_ff <= in_data.digits;
         blank_ff  <= in_data.blank;
      end
   end

endmodule

/* design/binary_to_decimal_ascii_blanked.sv */
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_blanked
// 32-bit unsigned to ten ASCII decimal characters with leading-zero blanking.
// ----------------------------------------------------------------------------
// Each value beat on req_ yields ten rsp_ beats, most significant digit first
// (digit_pos 0..9, last on 9). Leading zeros come out as the csr blank
// character; a zero value gives ten blanks. A value passes a ten-stage digit
// pipeline (one digit per stage) and then the output serializer. The pipeline
// takes a value every cycle while it has room, but the serializer drives one
// character per cycle while rsp_stall is low on the single result channel, so
// the serializer limits the sustained value rate.
module binary_to_decimal_ascii_blanked
   import b2da_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_blank_char,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_char_out,
   output logic [3:0]  rsp_digit_pos,
   output logic        rsp_last
);

   logic [CHAR_W-1:0]      blank_char_ff;
   logic [NUM_DIGITS:0]    vld;
   logic [NUM_DIGITS:0]    take;
   pipe_type [NUM_DIGITS:0] data;
   pipe_type               head_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         blank_char_ff <= BLANK_RST;
      end else if (csr_valid && csr_ready) begin
         blank_char_ff <= csr_blank_char;
      end
   end

   always_comb begin
      head_data      = '0;
      head_data.rest = req_value;
   end
   assign data[0]   = head_data;
   assign vld[0]    = req_valid;
   assign req_stall = !take[0];

   for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_stage
      b2da_stage #(.IDX(i)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (vld[i]),
         .in_data   (data[i]),
         .in_take   (take[i]),
         .out_valid (vld[i+1]),
         .out_data  (data[i+1]),
         .out_take  (take[i+1])
      );
   end

   b2da_ser u_ser (
      .clock         (clock),
      .reset         (reset),
      .blank_char    (blank_char_ff),
      .in_valid      (vld[NUM_DIGITS]),
      .in_data       (data[NUM_DIGITS]),
      .in_take       (take[NUM_DIGITS]),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_out  (rsp_char_out),
      .rsp_digit_pos (rsp_digit_pos),
      .rsp_last      (rsp_last)
   );

endmodule

/* tb/sv/b2da_text_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b2da_text_checker
// Watches the csr, req and rsp channels of the decimal ASCII converter,
// predicts the ten characters of every accepted value and compares each
// accepted rsp beat, field by field, with the oldest predicted character.
// ----------------------------------------------------------------------------
module b2da_text_checker
   import b2da_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   input  logic        csr_ready,
   input  logic [7:0]  csr_blank_char,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [31:0] req_value,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [7:0]  rsp_char_out,
   input  logic [3:0]  rsp_digit_pos,
   input  logic        rsp_last,
   output int          mismatch_count,
   output int          outstanding,
   output int          chars_checked
);

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic [POS_W-1:0]  pos;
      logic              last;
   } text_beat_type;

   text_beat_type     text_queue[$];
   logic [CHAR_W-1:0] blank_shadow = BLANK_RST;
   int                errors = 0;
   int                checked = 0;

   initial begin
      mismatch_count = 0;
      outstanding    = 0;
      chars_checked  = 0;
   end

   // Queue the ten characters of one value, most significant digit first.
   function automatic void predict_text(input logic [VALUE_W-1:0] value,
                                        input logic [CHAR_W-1:0]  blank);
      logic [VALUE_W-1:0] rest;
      logic [DIGIT_W-1:0] digit [NUM_DIGITS];
      bit                 leading;
      text_beat_type      beat;
      int                 k;
      rest = value;
      for (k = NUM_DIGITS - 1; k >= 0; k--) begin
         digit[k] = DIGIT_W'(rest % 32'd10);
         rest     = rest / 32'd10;
      end
      leading = 1'b1;
      for (k = 0; k < NUM_DIGITS; k++) begin
         if (digit[k] != '0)
            leading = 1'b0;
         // blank goes out as is, even when it happens to be a digit code
         beat.ch   = leading ? blank : ASCII_ZERO + {4'b0000, digit[k]};
         beat.pos  = POS_W'(k);
         beat.last = (POS_W'(k) == LAST_POS);
         text_queue.push_back(beat);
      end
   endfunction

   always @(posedge clock) begin
      text_beat_type want;
      if (reset) begin
         blank_shadow = BLANK_RST;
         text_queue.delete();
      end else begin
         if (csr_valid && csr_ready)
            blank_shadow = csr_blank_char;
         if (req_valid && !req_stall)
            predict_text(req_value, blank_shadow);
         if (rsp_valid && !rsp_stall) begin
            if (text_queue.size() == 0) begin
               errors++;
               $display("%0t: unexpected rsp beat: expected none, got %h pos %0d last %b",
                        $time, rsp_char_out, rsp_digit_pos, rsp_last);
            end else begin
               want = text_queue.pop_front();
               checked++;
               if (rsp_char_out !== want.ch) begin
                  errors++;
                  $display("%0t: char_out expected %h got %h (pos %0d)",
                           $time, want.ch, rsp_char_out, want.pos);
               end
               if (rsp_digit_pos !== want.pos) begin
                  errors++;
                  $display("%0t: digit_pos expected %0d got %0d",
                           $time, want.pos, rsp_digit_pos);
               end
               if (rsp_last !== want.last) begin
                  errors++;
                  $display("%0t: last expected %b got %b (pos %0d)",
                           $time, want.last, rsp_last, want.pos);
               end
            end
         end
      end
      // published after the edge so readers at the edge see settled values
      mismatch_count <= errors;
      outstanding    <= text_queue.size();
      chars_checked  <= checked;
   end

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for binary_to_decimal_ascii_blanked: directed values
// and blank codes, then random values of every magnitude over phases of
// sender gaps, receiver stalls and a long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
   import b2da_pkg::*;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        csr_valid      = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_blank_char = BLANK_RST;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [31:0] req_value      = '0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [7:0]  rsp_char_out;
   logic [3:0]  rsp_digit_pos;
   logic        rsp_last;

   int mismatch_count;
   int outstanding;
   int chars_checked;

   int          stall_pct   = 0;
   int unsigned cycle_count = 0;
   int unsigned hold_end    = 0;
   int          sender_idle = 0;
   int          values_sent = 0;
   int          blank_writes = 0;

   binary_to_decimal_ascii_blanked i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_blank_char (csr_blank_char),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_char_out   (rsp_char_out),
      .rsp_digit_pos  (rsp_digit_pos),
      .rsp_last       (rsp_last)
   );

   b2da_text_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_blank_char (csr_blank_char),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_char_out   (rsp_char_out),
      .rsp_digit_pos  (rsp_digit_pos),
      .rsp_last       (rsp_last),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .chars_checked  (chars_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Receiver: random stalls, plus a hold-off window counted here in cycles.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      rsp_stall   <= (cycle_count < hold_end) || ($urandom_range(99, 0) < stall_pct);
   end

   initial begin
      #4000000;
      $display("Mismatches found");
      $finish;
   end

   task automatic send_value(input logic [31:0] value);
      req_valid <= 1'b1;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      values_sent++;
   endtask

   task automatic sender_gap();
      if ($urandom_range(99, 0) < sender_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99, 0) < sender_idle);
      end
   endtask

   task automatic wait_text_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
   endtask

   task automatic write_blank(input logic [7:0] code);
      csr_valid      <= 1'b1;
      csr_blank_char <= code;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      blank_writes++;
   endtask

   // Mix of zero, full-range values, values with scattered zero digits and
   // values of a uniformly chosen decimal length.
   function automatic logic [31:0] random_value();
      logic [63:0] wide;
      logic [63:0] lo;
      logic [63:0] hi;
      int unsigned pick;
      int unsigned n_digits;
      pick     = $urandom_range(99, 0);
      n_digits = $urandom_range(10, 1);
      if (pick < 5)
         return '0;
      if (pick < 25)
         return $urandom();
      if (pick < 55) begin
         wide = '0;
         repeat (n_digits)
            wide = wide * 10 + ($urandom_range(1, 0) ? 0 : $urandom_range(9, 1));
         if (wide > 64'hFFFF_FFFF)
            wide = wide % 64'd1000000000;
         return wide[31:0];
      end
      lo = 64'd1;
      repeat (n_digits - 1) lo = lo * 10;
      hi = lo * 10 - 1;
      if (hi > 64'hFFFF_FFFF)
         hi = 64'hFFFF_FFFF;
      return $urandom_range(hi[31:0], lo[31:0]);
   endfunction

   task automatic run_phase(input int n_values, input int idle_pct, input int stall_v,
                            input logic [7:0] blank);
      wait_text_drained();
      write_blank(blank);
      sender_idle = idle_pct;
      stall_pct  <= stall_v;
      repeat (n_values) begin
         sender_gap();
         send_value(random_value());
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, blank at its reset value
      send_value(32'd0);
      send_value(32'd1);
      send_value(32'd9);
      send_value(32'd10);
      send_value(32'd99);
      send_value(32'd100);
      send_value(32'd999999999);
      send_value(32'd1000000000);
      send_value(32'd1000000001);
      send_value(32'd10203040);
      send_value(32'd1234567890);
      send_value(32'd2147483648);
      send_value(32'd4000000000);
      send_value(32'd4294967294);
      send_value(32'hFFFF_FFFF);

      wait_text_drained();
      write_blank(8'h00);
      send_value(32'd0);
      send_value(32'd5);
      send_value(32'hFFFF_FFFF);

      wait_text_drained();
      write_blank(8'hFF);
      send_value(32'd0);
      send_value(32'd42);

      // blank that is itself a digit code
      wait_text_drained();
      write_blank(ASCII_ZERO);
      send_value(32'd0);
      send_value(32'd1000);

      wait_text_drained();
      write_blank(ASCII_ZERO + 8'd9);
      send_value(32'd120);

      run_phase(80, 0, 0, 8'h2E);
      run_phase(80, 55, 0, 8'(BLANK_RST));
      run_phase(80, 0, 55, 8'h00);
      run_phase(40, 18, 18, 8'(ASCII_ZERO));
      // sender pauses mid-phase until all beats are out
      wait_text_drained();
      repeat (40) begin
         sender_gap();
         send_value(random_value());
      end
      run_phase(80, 30, 30, 8'($urandom_range(255, 0)));

      // long output hold-off while the sender keeps offering values
      wait_text_drained();
      write_blank(8'hFF);
      sender_idle = 0;
      stall_pct  <= 0;
      hold_end   <= cycle_count + 300;
      repeat (30) send_value(random_value());

      wait_text_drained();
      repeat (24) @(posedge clock);

      $display("Converted %0d values into %0d checked characters over %0d blank settings,",
               values_sent, chars_checked, blank_writes);
      $display("with gaps, stalls, a digit-code blank and a 300-cycle output hold-off.");
      if (outstanding != 0)
         $display("%0d predicted characters never arrived", outstanding);
      if (mismatch_count == 0 && outstanding == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
